// ----- rtl/core/unit_expression_tokenizer_defines.svh -----
// Assertion helpers for the tokenizer RTL.
// Each one samples on clk and is disabled while arst_n is low.
`ifndef UNIT_EXPRESSION_TOKENIZER_DEFINES_SVH
`define UNIT_EXPRESSION_TOKENIZER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define UET_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define UET_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/uet_pkg.sv -----
package uet_pkg;

	// Exponent format: magnitude saturates at 2^(ExpBits-1)-1
	localparam int ExpBits = 16;
	localparam int MagW    = ExpBits - 1;
	localparam int PayW    = 16;
	localparam int MaxRes  = 3;
	localparam int QDepth  = 4;
	localparam int QPtrW   = $clog2(QDepth);
	localparam int TDataW  = 32;

	localparam logic [MagW-1:0] MagMax = {MagW{1'b1}};

	// Characters with a meaning in the grammar
	localparam logic [7:0] ChStar  = 8'h2a;
	localparam logic [7:0] ChDot   = 8'h2e;
	localparam logic [7:0] ChCaret = 8'h5e;
	localparam logic [7:0] ChSlash = 8'h2f;
	localparam logic [7:0] ChOpen  = 8'h28;
	localparam logic [7:0] ChClose = 8'h29;
	localparam logic [7:0] ChUnder = 8'h5f;
	localparam logic [7:0] ChMinus = 8'h2d;
	localparam logic [7:0] ChPlus  = 8'h2b;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChDel   = 8'h7f;

	typedef enum logic [1:0] {
		KindSym  = 2'd0,
		KindTerm = 2'd1,
		KindDone = 2'd2,
		KindErr  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ErrEmpty    = 3'd0,
		ErrNoSym    = 3'd1,
		ErrCaretInt = 3'd2,
		ErrImplInt  = 3'd3,
		ErrEmptyPar = 3'd4,
		ErrNoClose  = 3'd5,
		ErrUnexp    = 3'd6
	} err_t;

	// One result: kind plus a payload holding the character, exponent or error code
	typedef struct packed {
		kind_t           kind;
		logic [PayW-1:0] pay;
	} rec_t;

	// All results caused by one character
	typedef struct packed {
		logic [1:0]              cnt;
		rec_t [MaxRes-1:0]       rec;
	} bundle_t;

	function automatic rec_t mk_rec(kind_t kind, logic [PayW-1:0] pay);
		rec_t r;
		r.kind = kind;
		r.pay  = pay;
		return r;
	endfunction

	function automatic rec_t err_rec(err_t code);
		return mk_rec(KindErr, PayW'(code));
	endfunction

	// Append a result at the end of a bundle
	function automatic bundle_t append(bundle_t b, rec_t r);
		bundle_t o;
		o = b;
		if (b.cnt < 2'(MaxRes)) begin
			o.rec[b.cnt] = r;
			o.cnt = b.cnt + 2'd1;
		end
		return o;
	endfunction

endpackage

// ----- rtl/core/uet_front.sv -----
module uet_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_char,
	input  logic                 in_last,
	output logic                 push,
	output uet_pkg::bundle_t     push_data,
	input  logic                 q_full
);

	typedef enum logic [8:0] {
		PhStart     = 9'b000000001,
		PhSym       = 9'b000000010,
		PhCaret     = 9'b000000100,
		PhCaretSign = 9'b000001000,
		PhImplSign  = 9'b000010000,
		PhDigits    = 9'b000100000,
		PhSlash     = 9'b001000000,
		PhOpen      = 9'b010000000,
		PhClose     = 9'b100000000
	} phase_t;

	phase_t                  phase_q, phase_v;
	logic                    den_q, den_v;
	logic                    par_q, par_v;
	logic                    neg_q, neg_v;
	logic [uet_pkg::MagW-1:0] mag_q, mag_v;
	logic                    err_q, err_v;
	logic                    any_q, any_v;
	uet_pkg::bundle_t        bnd_v;

	logic [7:0]              lc;
	logic                    letter, digit, skip, mul, after;
	logic [uet_pkg::MagW+3:0] acc;

	logic accept;

	// Term result from the given exponent state
	function automatic uet_pkg::rec_t term_rec(logic [uet_pkg::MagW-1:0] mag, logic neg,
			logic den);
		logic [uet_pkg::PayW-1:0] v;
		v = uet_pkg::PayW'(mag);
		if (neg ^ den) begin
			v = -v;
		end
		return uet_pkg::mk_rec(uet_pkg::KindTerm, v);
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Classify the character
	always_comb begin
		lc     = in_char | 8'h20;
		letter = (in_char < 8'd128) && (lc inside {[8'h61:8'h7a]});
		digit  = in_char inside {[8'h30:8'h39]};
		skip   = (in_char < 8'd32) || (in_char == uet_pkg::ChDel) ||
			(in_char == uet_pkg::ChSpace);
		mul    = (in_char == uet_pkg::ChStar) || (in_char == uet_pkg::ChDot);
		acc    = (uet_pkg::MagW+4)'({mag_q, 3'b000}) +
			(uet_pkg::MagW+4)'({mag_q, 1'b0}) +
			(uet_pkg::MagW+4)'(in_char - uet_pkg::ChZero);
	end

	// Advance the parser and collect the results of this character
	always_comb begin
		phase_v = phase_q;
		den_v   = den_q;
		par_v   = par_q;
		neg_v   = neg_q;
		mag_v   = mag_q;
		err_v   = err_q;
		any_v   = any_q;
		bnd_v   = '0;
		after   = 1'b0;

		if (!err_q && !skip) begin
			any_v = 1'b1;
			case (phase_q)
				PhStart: begin
					if (letter) begin
						bnd_v   = uet_pkg::append(bnd_v,
							uet_pkg::mk_rec(uet_pkg::KindSym, uet_pkg::PayW'(in_char)));
						phase_v = PhSym;
						mag_v   = uet_pkg::MagW'(1);
						neg_v   = 1'b0;
					end else begin
						bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(uet_pkg::ErrNoSym));
						err_v = 1'b1;
					end
				end
				PhSym: begin
					if (letter || digit || in_char == uet_pkg::ChUnder) begin
						bnd_v = uet_pkg::append(bnd_v,
							uet_pkg::mk_rec(uet_pkg::KindSym, uet_pkg::PayW'(in_char)));
					end else if (in_char == uet_pkg::ChCaret) begin
						phase_v = PhCaret;
					end else if (in_char == uet_pkg::ChMinus) begin
						neg_v   = 1'b1;
						phase_v = PhImplSign;
					end else begin
						bnd_v = uet_pkg::append(bnd_v, term_rec(mag_q, neg_q, den_q));
						after = 1'b1;
					end
				end
				PhCaret: begin
					if (in_char == uet_pkg::ChMinus) begin
						neg_v   = 1'b1;
						phase_v = PhCaretSign;
					end else if (in_char == uet_pkg::ChPlus) begin
						phase_v = PhCaretSign;
					end else if (digit) begin
						mag_v   = uet_pkg::MagW'(in_char[3:0]);
						phase_v = PhDigits;
					end else begin
						bnd_v = uet_pkg::append(bnd_v,
							uet_pkg::err_rec(uet_pkg::ErrCaretInt));
						err_v = 1'b1;
					end
				end
				PhCaretSign, PhImplSign: begin
					if (digit) begin
						mag_v   = uet_pkg::MagW'(in_char[3:0]);
						phase_v = PhDigits;
					end else begin
						bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(
							(phase_q == PhCaretSign) ? uet_pkg::ErrCaretInt
							: uet_pkg::ErrImplInt));
						err_v = 1'b1;
					end
				end
				PhDigits: begin
					if (digit) begin
						mag_v = (acc > (uet_pkg::MagW+4)'(uet_pkg::MagMax)) ? uet_pkg::MagMax
							: acc[uet_pkg::MagW-1:0];
					end else begin
						bnd_v = uet_pkg::append(bnd_v, term_rec(mag_q, neg_q, den_q));
						after = 1'b1;
					end
				end
				PhSlash: begin
					den_v = 1'b1;
					if (in_char == uet_pkg::ChOpen) begin
						par_v   = 1'b1;
						phase_v = PhOpen;
					end else if (letter) begin
						par_v   = 1'b0;
						bnd_v   = uet_pkg::append(bnd_v,
							uet_pkg::mk_rec(uet_pkg::KindSym, uet_pkg::PayW'(in_char)));
						phase_v = PhSym;
						mag_v   = uet_pkg::MagW'(1);
						neg_v   = 1'b0;
					end else begin
						bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(uet_pkg::ErrNoSym));
						err_v = 1'b1;
					end
				end
				PhOpen: begin
					if (in_char == uet_pkg::ChClose) begin
						bnd_v = uet_pkg::append(bnd_v,
							uet_pkg::err_rec(uet_pkg::ErrEmptyPar));
						err_v = 1'b1;
					end else if (letter) begin
						bnd_v   = uet_pkg::append(bnd_v,
							uet_pkg::mk_rec(uet_pkg::KindSym, uet_pkg::PayW'(in_char)));
						phase_v = PhSym;
						mag_v   = uet_pkg::MagW'(1);
						neg_v   = 1'b0;
					end else begin
						bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(uet_pkg::ErrNoSym));
						err_v = 1'b1;
					end
				end
				PhClose: begin
					if (in_char == uet_pkg::ChSlash) begin
						phase_v = PhSlash;
					end else begin
						bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(uet_pkg::ErrUnexp));
						err_v = 1'b1;
					end
				end
				default: begin
					bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(uet_pkg::ErrUnexp));
					err_v = 1'b1;
				end
			endcase

			// Decide what may follow a finished term
			if (after) begin
				if (par_q) begin
					if (mul) begin
						phase_v = PhStart;
					end else if (in_char == uet_pkg::ChClose) begin
						par_v   = 1'b0;
						phase_v = PhClose;
					end else begin
						bnd_v = uet_pkg::append(bnd_v,
							uet_pkg::err_rec(uet_pkg::ErrNoClose));
						err_v = 1'b1;
					end
				end else if (in_char == uet_pkg::ChSlash) begin
					phase_v = PhSlash;
				end else if (mul && !den_q) begin
					phase_v = PhStart;
				end else begin
					bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(uet_pkg::ErrUnexp));
					err_v = 1'b1;
				end
			end
		end

		// Close the expression on the last character
		if (in_last) begin
			if (!err_v) begin
				if (!any_v) begin
					bnd_v = uet_pkg::append(bnd_v, uet_pkg::err_rec(uet_pkg::ErrEmpty));
				end else begin
					case (phase_v)
						PhSym, PhDigits: begin
							bnd_v = uet_pkg::append(bnd_v, term_rec(mag_v, neg_v, den_v));
							if (par_v) begin
								bnd_v = uet_pkg::append(bnd_v,
									uet_pkg::err_rec(uet_pkg::ErrNoClose));
							end else begin
								bnd_v = uet_pkg::append(bnd_v,
									uet_pkg::mk_rec(uet_pkg::KindDone, '0));
							end
						end
						PhStart, PhSlash: begin
							bnd_v = uet_pkg::append(bnd_v,
								uet_pkg::err_rec(uet_pkg::ErrNoSym));
						end
						PhOpen: begin
							bnd_v = uet_pkg::append(bnd_v,
								uet_pkg::err_rec(uet_pkg::ErrEmptyPar));
						end
						PhCaret, PhCaretSign: begin
							bnd_v = uet_pkg::append(bnd_v,
								uet_pkg::err_rec(uet_pkg::ErrCaretInt));
						end
						PhImplSign: begin
							bnd_v = uet_pkg::append(bnd_v,
								uet_pkg::err_rec(uet_pkg::ErrImplInt));
						end
						PhClose: begin
							bnd_v = uet_pkg::append(bnd_v,
								uet_pkg::mk_rec(uet_pkg::KindDone, '0));
						end
						default: begin
							bnd_v = uet_pkg::append(bnd_v,
								uet_pkg::err_rec(uet_pkg::ErrUnexp));
						end
					endcase
				end
			end
			phase_v = PhStart;
			den_v   = 1'b0;
			par_v   = 1'b0;
			neg_v   = 1'b0;
			mag_v   = '0;
			err_v   = 1'b0;
			any_v   = 1'b0;
		end
	end

	assign push      = accept && (bnd_v.cnt != 2'd0);
	assign push_data = bnd_v;

	// Hold the parser state between characters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhStart;
			den_q   <= 1'b0;
			par_q   <= 1'b0;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			err_q   <= 1'b0;
			any_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_v;
			den_q   <= den_v;
			par_q   <= par_v;
			neg_q   <= neg_v;
			mag_q   <= mag_v;
			err_q   <= err_v;
			any_q   <= any_v;
		end
	end

endmodule

// ----- rtl/core/uet_queue.sv -----
module uet_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  uet_pkg::bundle_t push_data,
	output logic             full,
	output logic             valid,
	output uet_pkg::bundle_t data,
	input  logic             pop
);

	uet_pkg::bundle_t             mem_q [uet_pkg::QDepth];
	logic [uet_pkg::QPtrW-1:0]    wr_q, rd_q;
	logic [uet_pkg::QPtrW:0]      cnt_q;
	logic                         do_push, do_pop;

	assign full    = cnt_q == (uet_pkg::QPtrW+1)'(uet_pkg::QDepth);
	assign valid   = cnt_q != '0;
	assign data    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Store bundles at the write pointer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/uet_back.sv -----
`include "unit_expression_tokenizer_defines.svh"

module uet_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  uet_pkg::bundle_t          q_data,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [uet_pkg::TDataW-1:0] out_data,
	output logic [1:0]                out_kind,
	output logic                      out_last
);

	logic [1:0]     idx_q;
	uet_pkg::rec_t  out_rec_q;
	logic           out_last_q, out_valid_q;
	logic           load, rec_last;

	assign load     = q_valid && (!out_valid_q || out_ready);
	assign rec_last = idx_q == (q_data.cnt - 2'd1);
	assign q_pop    = load && rec_last;

	// Walk through the head bundle one result per cycle while the output is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= rec_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the result in the output register
	always_ff @(posedge clk) begin
		if (load) begin
			out_rec_q  <= q_data.rec[idx_q];
			out_last_q <= rec_last;
		end
	end

	// Place the payload in its field, others zero
	always_comb begin
		out_data = '0;
		case (out_rec_q.kind)
			uet_pkg::KindSym:  out_data[7:0]   = out_rec_q.pay[7:0];
			uet_pkg::KindTerm: out_data[23:8]  = out_rec_q.pay;
			uet_pkg::KindErr:  out_data[26:24] = out_rec_q.pay[2:0];
			default:           out_data        = '0;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_rec_q.kind;
	assign out_last  = out_last_q;

	`UET_ASSERT_IMP(a_err_ends_run, out_valid && out_kind == uet_pkg::KindErr, out_last, "error result not last of run")
	`UET_ASSERT_IMP(a_done_ends_run, out_valid && out_kind == uet_pkg::KindDone, out_last, "done result not last of run")
	`UET_ASSERT_IMP(a_sym_fields, out_valid && out_kind == uet_pkg::KindSym, out_data[31:8] == '0, "symbol result carries stray fields")
	`UET_ASSERT(a_idx_in_bundle, !q_valid || (idx_q < q_data.cnt), "result index beyond bundle")

endmodule

// ----- rtl/core/unit_expression_tokenizer.sv -----
// Unit expression tokenizer.
// Input stream (s_*): one character per request, s_tlast on the final character
// of an expression. Output stream (m_*): symbol characters, term-complete with
// signed exponent, expression-done, or an error code; m_tlast marks the final
// result caused by one input character.
// Throughput: one character per cycle. A character that causes several results
// sends them on the output one after another; a 4-entry queue between the
// parser and the output stage absorbs such bursts, so input stalls only when
// the queue fills.
// Path: the first result of a character is written to the queue and then to
// the output register before it is presented on m_*; each further result of
// that character follows it in order.
// Characters that cause no result (a caret, an exponent sign, skipped
// whitespace) take no queue entry.
// Reset: arst_n clears the parser to the start of an expression and empties the
// queue and the output register; no clearing pass is needed.
// Stall: while m_tready is low the output result holds, the queue fills, and
// s_tready drops when it is full.
module unit_expression_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] symbol_char, [23:8] term_exponent, [26:24] error_code
	output logic [1:0]  m_tuser,   // [1:0] result_kind
	output logic        m_tlast
);

	logic             push, full, q_valid, q_pop;
	uet_pkg::bundle_t push_data, q_data;

	// Parse characters into result bundles
	uet_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_char   (s_tdata),
		.in_last   (s_tlast),
		.push      (push),
		.push_data (push_data),
		.q_full    (full)
	);

	// Buffer bundles between parser and output
	uet_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.valid     (q_valid),
		.data      (q_data),
		.pop       (q_pop)
	);

	// Serialize bundles onto the output stream
	uet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule
